>>> hdl/jbsl_pkg.sv
// ----------------------------------------------------------------------------
// jbsl_pkg
// Types, codes and byte-level helpers shared by the JSON byte lexer modules.
// ----------------------------------------------------------------------------
package jbsl_pkg;

   // token kinds
   localparam logic [3:0] TK_STRING   = 4'd0;
   localparam logic [3:0] TK_NUMBER   = 4'd1;
   localparam logic [3:0] TK_LBRACKET = 4'd2;
   localparam logic [3:0] TK_RBRACKET = 4'd3;
   localparam logic [3:0] TK_LBRACE   = 4'd4;
   localparam logic [3:0] TK_RBRACE   = 4'd5;
   localparam logic [3:0] TK_COLON    = 4'd6;
   localparam logic [3:0] TK_COMMA    = 4'd7;
   localparam logic [3:0] TK_TRUE     = 4'd8;
   localparam logic [3:0] TK_FALSE    = 4'd9;
   localparam logic [3:0] TK_NULL     = 4'd10;
   localparam logic [3:0] TK_END      = 4'd11;
   localparam logic [3:0] TK_ERROR    = 4'd12;

   // fault codes
   localparam logic [2:0] FLT_NONE     = 3'd0;
   localparam logic [2:0] FLT_BAD_CHAR = 3'd1;
   localparam logic [2:0] FLT_BAD_WORD = 3'd2;
   localparam logic [2:0] FLT_BAD_ESC  = 3'd3;
   localparam logic [2:0] FLT_LONE_LOW = 3'd4;
   localparam logic [2:0] FLT_NO_PAIR  = 3'd5;
   localparam logic [2:0] FLT_BAD_LOW  = 3'd6;
   localparam logic [2:0] FLT_TRUNC    = 3'd7;

   // word classifier: number flag plus keyword matcher position
   localparam logic [4:0] WC_NUM_FLAG = 5'h10;
   localparam logic [3:0] KW_NONE     = 4'd0;
   localparam logic [3:0] KW_T        = 4'd1;
   localparam logic [3:0] KW_TRUE_OK  = 4'd4;
   localparam logic [3:0] KW_F        = 4'd5;
   localparam logic [3:0] KW_FALSE_OK = 4'd9;
   localparam logic [3:0] KW_N        = 4'd10;
   localparam logic [3:0] KW_NULL_OK  = 4'd13;
   localparam logic [3:0] KW_START    = 4'd14;
   localparam logic [4:0] WC_RESET    = WC_NUM_FLAG | {1'b0, KW_START};

   // characters
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LO_B   = 8'h62;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_LO_N   = 8'h6E;
   localparam logic [7:0] CH_LO_R   = 8'h72;
   localparam logic [7:0] CH_LO_T   = 8'h74;
   localparam logic [7:0] CH_LO_U   = 8'h75;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic        token_done;
      logic        has_text;
      logic [7:0]  text_out;
      logic [2:0]  fault;
      logic [15:0] line_no;
      logic [15:0] column_no;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [3:0] kind;
      logic       done;
      logic       has_text;
      logic [7:0] text;
      logic [2:0] fault;
   } tok_type;

   // all results caused by one input byte
   typedef struct packed {
      tok_type [3:0] toks;
      logic [2:0]    count;
      logic [15:0]   line_no;
      logic [15:0]   column_no;
   } bundle_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } utf8_type;

   function automatic tok_type mk_tok(logic [3:0] kind, logic done, logic ht,
                                      logic [7:0] text, logic [2:0] fault);
      tok_type t;
      t.kind = kind;
      t.done = done;
      t.has_text = ht;
      t.text = text;
      t.fault = fault;
      return t;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_word(logic [7:0] b);
      return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
             ((b >= 8'h41) && (b <= 8'h5A)) || (b == CH_UNDER) || (b == CH_DOT);
   endfunction

   function automatic logic [7:0] kw_next(logic [3:0] kw);
      logic [7:0] c;
      case (kw)
         4'd1:    c = 8'h72;
         4'd2:    c = 8'h75;
         4'd3:    c = 8'h65;
         4'd5:    c = 8'h61;
         4'd6:    c = 8'h6C;
         4'd7:    c = 8'h73;
         4'd8:    c = 8'h65;
         4'd10:   c = 8'h75;
         4'd11:   c = 8'h6C;
         4'd12:   c = 8'h6C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [4:0] word_feed(logic [4:0] wc, logic [7:0] b);
      logic [3:0] kw;
      logic       num;
      kw  = wc[3:0];
      num = wc[4] && (is_digit(b) || (b == CH_DOT));
      if (kw == KW_START) begin
         kw = (b == CH_LO_T) ? KW_T : (b == CH_LO_F) ? KW_F :
              (b == CH_LO_N) ? KW_N : KW_NONE;
      end else if ((kw_next(kw) != 8'h00) && (kw_next(kw) == b)) begin
         kw = kw + 4'd1;
      end else begin
         kw = KW_NONE;
      end
      return {num, kw};
   endfunction

   // {bad, value}
   function automatic logic [4:0] hex_val(logic [7:0] b);
      logic [4:0] r;
      if (is_digit(b)) r = {1'b0, 4'(b - 8'h30)};
      else if ((b >= 8'h41) && (b <= 8'h46)) r = {1'b0, 4'(b - 8'h37)};
      else if ((b >= 8'h61) && (b <= 8'h66)) r = {1'b0, 4'(b - 8'h57)};
      else r = 5'h10;
      return r;
   endfunction

   function automatic utf8_type utf8_encode(logic [20:0] cp);
      utf8_type u;
      u.bytes = '0;
      if (cp < 21'h80) begin
         u.bytes[0] = cp[7:0];
         u.count = 3'd1;
      end else if (cp < 21'h800) begin
         u.bytes[0] = {3'b110, cp[10:6]};
         u.bytes[1] = {2'b10, cp[5:0]};
         u.count = 3'd2;
      end else if (cp < 21'h10000) begin
         u.bytes[0] = {4'b1110, cp[15:12]};
         u.bytes[1] = {2'b10, cp[11:6]};
         u.bytes[2] = {2'b10, cp[5:0]};
         u.count = 3'd3;
      end else begin
         u.bytes[0] = {5'b11110, cp[20:18]};
         u.bytes[1] = {2'b10, cp[17:12]};
         u.bytes[2] = {2'b10, cp[11:6]};
         u.bytes[3] = {2'b10, cp[5:0]};
         u.count = 3'd4;
      end
      return u;
   endfunction

endpackage

>>> hdl/jbsl_fifo.sv
// ----------------------------------------------------------------------------
// jbsl_fifo
// Small register queue with the head word visible combinationally.
// ----------------------------------------------------------------------------
module jbsl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/jbsl_front.sv
// ----------------------------------------------------------------------------
// jbsl_front
// Byte classifier and lexer state: turns one byte into a bundle of results.
// ----------------------------------------------------------------------------
module jbsl_front #(
   parameter int POSITION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  jbsl_pkg::req_type    req,
   output logic                 push,
   output jbsl_pkg::bundle_type bundle
);

   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_STR, M_ESC,
      M_HEX1, M_PBS, M_PU, M_HEX2, M_WORD, M_SINK
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [1:0]               hc_ff, hc_in;
   logic [15:0]              acc_ff, acc_in;
   logic                     bad_ff, bad_in;
   logic [9:0]               high_ff, high_in;
   logic [4:0]               wc_ff, wc_in;
   logic [POSITION_BITS-1:0] line_ff, line_in, col_ff, col_in, line_pos, col_pos;

   jbsl_pkg::tok_type [3:0]  toks;
   logic [2:0]               n;
   logic                     run_idle, any_text;
   logic [7:0]               b;
   logic [4:0]               hv;
   logic [15:0]              acc_next, unit;
   logic                     bad_next;
   logic [20:0]              cp;
   jbsl_pkg::utf8_type       enc;
   logic [3:0]               close_kind;
   logic                     close_ok;

   assign b = req.data_byte;

   always_comb begin
      mode_in  = mode_ff;
      hc_in    = hc_ff;
      acc_in   = acc_ff;
      bad_in   = bad_ff;
      high_in  = high_ff;
      wc_in    = wc_ff;
      toks     = '0;
      n        = '0;
      run_idle = 1'b0;
      any_text = 1'b0;
      cp       = '0;
      enc      = '0;

      // position after this byte
      if (b == jbsl_pkg::CH_LF) begin
         line_pos = (line_ff == {POSITION_BITS{1'b1}}) ? line_ff
                    : line_ff + POSITION_BITS'(1);
         col_pos  = '0;
      end else begin
         line_pos = line_ff;
         col_pos  = (col_ff == {POSITION_BITS{1'b1}}) ? col_ff
                    : col_ff + POSITION_BITS'(1);
      end

      hv       = jbsl_pkg::hex_val(b);
      acc_next = {acc_ff[11:0], hv[3:0]};
      bad_next = bad_ff | hv[4];
      unit     = bad_next ? 16'h0000 : acc_next;

      // word close kind, from the class before this byte
      close_ok = 1'b1;
      if (wc_ff[4]) close_kind = jbsl_pkg::TK_NUMBER;
      else if (wc_ff[3:0] == jbsl_pkg::KW_TRUE_OK) close_kind = jbsl_pkg::TK_TRUE;
      else if (wc_ff[3:0] == jbsl_pkg::KW_FALSE_OK) close_kind = jbsl_pkg::TK_FALSE;
      else if (wc_ff[3:0] == jbsl_pkg::KW_NULL_OK) close_kind = jbsl_pkg::TK_NULL;
      else begin
         close_kind = jbsl_pkg::TK_ERROR;
         close_ok   = 1'b0;
      end

      case (mode_ff)
         M_IDLE: run_idle = 1'b1;
         M_SLASH: begin
            if (b == jbsl_pkg::CH_SLASH) mode_in = M_LINE;
            else if (b == jbsl_pkg::CH_STAR) mode_in = M_BLOCK;
            else begin
               toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0, 8'h00,
                                          jbsl_pkg::FLT_BAD_CHAR);
               n = 3'd1;
               mode_in = M_SINK;
            end
         end
         M_LINE: if (b == jbsl_pkg::CH_LF) mode_in = M_IDLE;
         M_BLOCK: if (b == jbsl_pkg::CH_STAR) mode_in = M_BSTAR;
         M_BSTAR: begin
            if (b == jbsl_pkg::CH_SLASH) mode_in = M_IDLE;
            else if (b != jbsl_pkg::CH_STAR) mode_in = M_BLOCK;
         end
         M_STR: begin
            if (b == jbsl_pkg::CH_QUOTE) begin
               toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING, 1'b1, 1'b0, 8'h00,
                                          jbsl_pkg::FLT_NONE);
               n = 3'd1;
               mode_in = M_IDLE;
            end else if (b == jbsl_pkg::CH_BSLASH) begin
               mode_in = M_ESC;
            end else begin
               toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING, 1'b0, 1'b1, b,
                                          jbsl_pkg::FLT_NONE);
               n = 3'd1;
            end
         end
         M_ESC: begin
            mode_in = M_STR;
            n = 3'd1;
            case (b)
               jbsl_pkg::CH_LO_B: toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING,
                                      1'b0, 1'b1, 8'h08, jbsl_pkg::FLT_NONE);
               jbsl_pkg::CH_LO_F: toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING,
                                      1'b0, 1'b1, 8'h0C, jbsl_pkg::FLT_NONE);
               jbsl_pkg::CH_LO_N: toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING,
                                      1'b0, 1'b1, 8'h0A, jbsl_pkg::FLT_NONE);
               jbsl_pkg::CH_LO_R: toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING,
                                      1'b0, 1'b1, 8'h0D, jbsl_pkg::FLT_NONE);
               jbsl_pkg::CH_LO_T: toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING,
                                      1'b0, 1'b1, 8'h09, jbsl_pkg::FLT_NONE);
               jbsl_pkg::CH_QUOTE, jbsl_pkg::CH_BSLASH, jbsl_pkg::CH_SLASH:
                  toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING, 1'b0, 1'b1, b,
                                             jbsl_pkg::FLT_NONE);
               jbsl_pkg::CH_LO_U: begin
                  n = 3'd0;
                  mode_in = M_HEX1;
                  hc_in = '0;
                  acc_in = '0;
                  bad_in = 1'b0;
               end
               default: begin
                  toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0, 8'h00,
                                             jbsl_pkg::FLT_BAD_ESC);
                  mode_in = M_SINK;
               end
            endcase
         end
         M_HEX1, M_HEX2: begin
            if (hc_ff == 2'd3) begin
               hc_in  = '0;
               acc_in = '0;
               bad_in = 1'b0;
               if (mode_ff == M_HEX1) begin
                  if ((unit >= 16'hDC00) && (unit <= 16'hDFFF)) begin
                     toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0,
                                                8'h00, jbsl_pkg::FLT_LONE_LOW);
                     n = 3'd1;
                     mode_in = M_SINK;
                  end else if ((unit >= 16'hD800) && (unit <= 16'hDBFF)) begin
                     high_in = unit[9:0];
                     mode_in = M_PBS;
                  end else begin
                     cp = {5'd0, unit};
                     mode_in = M_STR;
                  end
               end else begin
                  if ((unit < 16'hDC00) || (unit > 16'hDFFF)) begin
                     toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0,
                                                8'h00, jbsl_pkg::FLT_BAD_LOW);
                     n = 3'd1;
                     mode_in = M_SINK;
                  end else begin
                     cp = 21'h10000 + {1'b0, high_ff, unit[9:0]};
                     mode_in = M_STR;
                  end
               end
               if (mode_in == M_STR) begin
                  enc = jbsl_pkg::utf8_encode(cp);
                  for (int i = 0; i < 4; i++) begin
                     toks[i] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING, 1'b0, 1'b1,
                                                enc.bytes[i], jbsl_pkg::FLT_NONE);
                  end
                  n = enc.count;
               end
            end else begin
               hc_in  = hc_ff + 2'd1;
               acc_in = acc_next;
               bad_in = bad_next;
            end
         end
         M_PBS: begin
            if (b == jbsl_pkg::CH_BSLASH) mode_in = M_PU;
            else begin
               toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0, 8'h00,
                                          jbsl_pkg::FLT_NO_PAIR);
               n = 3'd1;
               mode_in = M_SINK;
            end
         end
         M_PU: begin
            if (b == jbsl_pkg::CH_LO_U) begin
               mode_in = M_HEX2;
               hc_in = '0;
               acc_in = '0;
               bad_in = 1'b0;
            end else begin
               toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0, 8'h00,
                                          jbsl_pkg::FLT_NO_PAIR);
               n = 3'd1;
               mode_in = M_SINK;
            end
         end
         M_WORD: begin
            if (jbsl_pkg::is_word(b)) begin
               wc_in = jbsl_pkg::word_feed(wc_ff, b);
               toks[0] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING, 1'b0, 1'b1, b,
                                          jbsl_pkg::FLT_NONE);
               n = 3'd1;
            end else begin
               toks[0] = jbsl_pkg::mk_tok(close_kind, 1'b1, 1'b0, 8'h00,
                            close_ok ? jbsl_pkg::FLT_NONE : jbsl_pkg::FLT_BAD_WORD);
               n = 3'd1;
               wc_in = jbsl_pkg::WC_RESET;
               mode_in = close_ok ? M_IDLE : M_SINK;
               run_idle = close_ok;
            end
         end
         default: ;
      endcase

      // byte seen between tokens
      if (run_idle) begin
         case (b)
            jbsl_pkg::CH_SPACE, jbsl_pkg::CH_TAB, jbsl_pkg::CH_CR, jbsl_pkg::CH_LF: ;
            jbsl_pkg::CH_QUOTE: mode_in = M_STR;
            jbsl_pkg::CH_SLASH: mode_in = M_SLASH;
            jbsl_pkg::CH_LBRK, jbsl_pkg::CH_RBRK, jbsl_pkg::CH_LBRACE,
            jbsl_pkg::CH_RBRACE, jbsl_pkg::CH_COLON, jbsl_pkg::CH_COMMA: begin
               toks[n[1:0]] = jbsl_pkg::mk_tok(
                  (b == jbsl_pkg::CH_LBRK)   ? jbsl_pkg::TK_LBRACKET :
                  (b == jbsl_pkg::CH_RBRK)   ? jbsl_pkg::TK_RBRACKET :
                  (b == jbsl_pkg::CH_LBRACE) ? jbsl_pkg::TK_LBRACE :
                  (b == jbsl_pkg::CH_RBRACE) ? jbsl_pkg::TK_RBRACE :
                  (b == jbsl_pkg::CH_COLON)  ? jbsl_pkg::TK_COLON : jbsl_pkg::TK_COMMA,
                  1'b1, 1'b0, 8'h00, jbsl_pkg::FLT_NONE);
               n = n + 3'd1;
            end
            default: begin
               if (jbsl_pkg::is_word(b)) begin
                  mode_in = M_WORD;
                  wc_in = jbsl_pkg::word_feed(jbsl_pkg::WC_RESET, b);
                  toks[n[1:0]] = jbsl_pkg::mk_tok(jbsl_pkg::TK_STRING, 1'b0, 1'b1, b,
                                                  jbsl_pkg::FLT_NONE);
               end else begin
                  mode_in = M_SINK;
                  toks[n[1:0]] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0,
                                                  8'h00, jbsl_pkg::FLT_BAD_CHAR);
               end
               n = n + 3'd1;
            end
         endcase
      end

      // final byte: close what is open, then the end token
      if (req.text_end) begin
         for (int i = 0; i < 4; i++) begin
            if ((3'(i) < n) && toks[i].has_text) any_text = 1'b1;
         end
         case (mode_in)
            M_SLASH: begin
               toks[n[1:0]] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0, 8'h00,
                                               jbsl_pkg::FLT_BAD_CHAR);
               n = n + 3'd1;
            end
            M_WORD: begin
               if (wc_in[4]) close_kind = jbsl_pkg::TK_NUMBER;
               else if (wc_in[3:0] == jbsl_pkg::KW_TRUE_OK) close_kind = jbsl_pkg::TK_TRUE;
               else if (wc_in[3:0] == jbsl_pkg::KW_FALSE_OK)
                  close_kind = jbsl_pkg::TK_FALSE;
               else if (wc_in[3:0] == jbsl_pkg::KW_NULL_OK) close_kind = jbsl_pkg::TK_NULL;
               else close_kind = jbsl_pkg::TK_ERROR;
               toks[n[1:0]] = jbsl_pkg::mk_tok(close_kind, 1'b1, 1'b0, 8'h00,
                  (close_kind == jbsl_pkg::TK_ERROR) ? jbsl_pkg::FLT_BAD_WORD
                                                     : jbsl_pkg::FLT_NONE);
               n = n + 3'd1;
            end
            M_STR, M_ESC, M_HEX1, M_PBS, M_PU, M_HEX2: begin
               // drop the content bytes of this byte; they trail any token
               if (any_text) n = '0;
               toks[n[1:0]] = jbsl_pkg::mk_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0, 8'h00,
                                               jbsl_pkg::FLT_TRUNC);
               n = n + 3'd1;
            end
            default: ;
         endcase
         if (n < 3'd4) begin
            toks[n[1:0]] = jbsl_pkg::mk_tok(jbsl_pkg::TK_END, 1'b1, 1'b0, 8'h00,
                                            jbsl_pkg::FLT_NONE);
            n = n + 3'd1;
         end
         mode_in = M_IDLE;
         hc_in   = '0;
         acc_in  = '0;
         bad_in  = 1'b0;
         high_in = '0;
         wc_in   = jbsl_pkg::WC_RESET;
         line_in = '0;
         col_in  = '0;
      end else begin
         line_in = line_pos;
         col_in  = col_pos;
      end
   end

   assign push             = take && (n != 3'd0);
   assign bundle.toks      = toks;
   assign bundle.count     = n;
   assign bundle.line_no   = 16'(line_pos);
   assign bundle.column_no = 16'(col_pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         hc_ff   <= '0;
         acc_ff  <= '0;
         bad_ff  <= 1'b0;
         high_ff <= '0;
         wc_ff   <= jbsl_pkg::WC_RESET;
         line_ff <= '0;
         col_ff  <= '0;
      end else if (take) begin
         mode_ff <= mode_in;
         hc_ff   <= hc_in;
         acc_ff  <= acc_in;
         bad_ff  <= bad_in;
         high_ff <= high_in;
         wc_ff   <= wc_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

endmodule

>>> hdl/jbsl_back.sv
// ----------------------------------------------------------------------------
// jbsl_back
// Unpacks queued bundles into single result words behind an output register.
// ----------------------------------------------------------------------------
module jbsl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  jbsl_pkg::bundle_type head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jbsl_pkg::rsp_type    rsp_data
);

   logic              valid_ff;
   logic [1:0]        idx_ff;
   jbsl_pkg::rsp_type rsp_ff, rsp_in;
   jbsl_pkg::tok_type cur;
   logic              load, last;

   assign cur   = head.toks[idx_ff];
   assign last  = ({1'b0, idx_ff} == (head.count - 3'd1));
   assign load  = !q_empty && (!valid_ff || rsp_ready);
   assign q_pop = load && last;

   always_comb begin
      rsp_in.token_kind = cur.kind;
      rsp_in.token_done = cur.done;
      rsp_in.has_text   = cur.has_text;
      rsp_in.text_out   = cur.text;
      rsp_in.fault      = cur.fault;
      rsp_in.line_no    = head.line_no;
      rsp_in.column_no  = head.column_no;
      rsp_in.run_last   = last;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/json_byte_stream_lexer.sv
// ----------------------------------------------------------------------------
// json_byte_stream_lexer
// JSON tokenizer: one text byte in per word, tokens and decoded bytes out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_ready  data_byte, text_end
//  rsp_     out        rsp_valid/rsp_ready  token_kind .. run_last
//
//  One byte is accepted per cycle while the bundle queue has room.
//  A byte gives 0 to 4 result words; results leave one per cycle while
//  rsp_ready is high. The bundle enters the queue at the accepting edge;
//  its first result word is then loaded into the output register.
//  Reset (synchronous) empties the queue and returns to between-tokens.
//  A stalled rsp_ side backs up through the queue to req_ready.
// ----------------------------------------------------------------------------
module json_byte_stream_lexer #(
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jbsl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jbsl_pkg::rsp_type rsp_data
);

   localparam int BUNDLE_W = $bits(jbsl_pkg::bundle_type);

   logic                 take, q_push, q_pop, q_full, q_empty;
   jbsl_pkg::bundle_type bundle, head;
   logic [BUNDLE_W-1:0]  head_bits;

   // accept whenever the queue can hold another bundle
   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   // front: classify the byte and advance lexer state
   jbsl_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .push  (q_push),
      .bundle(bundle)
   );

   // queue: hold bundles so either side can stall alone
   jbsl_fifo #(
      .WIDTH(BUNDLE_W),
      .DEPTH(jbsl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(bundle),
      .pop      (q_pop),
      .head     (head_bits),
      .full     (q_full),
      .empty    (q_empty)
   );

   assign head = jbsl_pkg::bundle_type'(head_bits);

   // back: drain each bundle one result word at a time
   jbsl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // never push into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("bundle pushed into full queue");

   // a finished token never carries content
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.token_done && rsp_data.has_text))
      else $error("content on a finished token");

   // fault codes only on error tokens
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.fault != jbsl_pkg::FLT_NONE)) |->
         (rsp_data.token_kind == jbsl_pkg::TK_ERROR))
      else $error("fault on non-error token");

   // end token always closes its byte's run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.token_kind == jbsl_pkg::TK_END) && rsp_data.token_done)
         |-> rsp_data.run_last)
      else $error("end token not last of run");

endmodule

>>> sim/json_byte_stream_lexer_tb.sv
// ----------------------------------------------------------------------------
// json_byte_stream_lexer_tb
// Feeds JSON-like byte streams (punctuation, strings with escapes and
// surrogate pairs, words, comments, broken input) into the lexer and checks
// every result word against a behavioral tokenizer kept in the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_byte_stream_lexer_tb;

   // lexer modes of the predictor
   typedef enum logic [3:0] {
      LM_IDLE, LM_SLASH, LM_LINE, LM_BLOCK, LM_BSTAR, LM_STR, LM_ESC, LM_HEX1,
      LM_PBS, LM_PU, LM_HEX2, LM_WORD, LM_SINK
   } lex_mode_type;

   localparam int POS_MAX = 65535;

   // -------------------------------------------------------------------------
   // Token predictor and store of expected result words
   // -------------------------------------------------------------------------
   class token_scoreboard;
      lex_mode_type        mode;
      int                  hex_n;
      logic [15:0]         accum;
      bit                  hex_err;
      logic [15:0]         high_half;
      logic [4:0]          wclass;
      int                  line_cnt, col_cnt;
      jbsl_pkg::tok_type   step_toks[$];
      jbsl_pkg::rsp_type   expected_words[$];
      int                  errors;

      function new();
         errors = 0;
         clear_all();
      endfunction

      function void clear_all();
         mode = LM_IDLE; hex_n = 0; accum = '0; hex_err = 0; high_half = '0;
         wclass = jbsl_pkg::WC_RESET; line_cnt = 0; col_cnt = 0;
      endfunction

      function void add_tok(logic [3:0] k, logic d, logic h, logic [7:0] t,
                            logic [2:0] f);
         if (step_toks.size() < 8) step_toks.push_back(jbsl_pkg::mk_tok(k, d, h, t, f));
      endfunction

      function void add_done(logic [3:0] k);
         add_tok(k, 1'b1, 1'b0, 8'h00, jbsl_pkg::FLT_NONE);
      endfunction

      function void raise_fault(logic [2:0] f);
         add_tok(jbsl_pkg::TK_ERROR, 1'b1, 1'b0, 8'h00, f);
         mode = LM_SINK;
      endfunction

      function void text_byte(logic [7:0] b);
         add_tok(jbsl_pkg::TK_STRING, 1'b0, 1'b1, b, jbsl_pkg::FLT_NONE);
      endfunction

      function void feed_word(logic [7:0] b);
         logic [3:0] kw;
         logic num;
         logic [7:0] nx;
         kw = wclass[3:0];
         num = wclass[4] && ((b >= "0" && b <= "9") || b == ".");
         case (kw)
            4'd1: nx = "r"; 4'd2: nx = "u"; 4'd3: nx = "e"; 4'd5: nx = "a";
            4'd6: nx = "l"; 4'd7: nx = "s"; 4'd8: nx = "e"; 4'd10: nx = "u";
            4'd11: nx = "l"; 4'd12: nx = "l"; default: nx = 8'h00;
         endcase
         if (kw == jbsl_pkg::KW_START)
            kw = (b == "t") ? jbsl_pkg::KW_T : (b == "f") ? jbsl_pkg::KW_F :
                 (b == "n") ? jbsl_pkg::KW_N : jbsl_pkg::KW_NONE;
         else if (nx != 8'h00 && nx == b) kw = kw + 4'd1;
         else kw = jbsl_pkg::KW_NONE;
         wclass = {num, kw};
      endfunction

      function bit word_char(logic [7:0] b);
         return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
                (b >= "A" && b <= "Z") || b == "_" || b == ".";
      endfunction

      function bit close_word();
         logic [3:0] kw;
         logic num;
         kw = wclass[3:0]; num = wclass[4];
         wclass = jbsl_pkg::WC_RESET; mode = LM_IDLE;
         if (num) add_done(jbsl_pkg::TK_NUMBER);
         else if (kw == jbsl_pkg::KW_TRUE_OK) add_done(jbsl_pkg::TK_TRUE);
         else if (kw == jbsl_pkg::KW_FALSE_OK) add_done(jbsl_pkg::TK_FALSE);
         else if (kw == jbsl_pkg::KW_NULL_OK) add_done(jbsl_pkg::TK_NULL);
         else begin
            raise_fault(jbsl_pkg::FLT_BAD_WORD);
            return 0;
         end
         return 1;
      endfunction

      function void idle_byte(logic [7:0] b);
         case (b)
            jbsl_pkg::CH_SPACE, jbsl_pkg::CH_TAB, jbsl_pkg::CH_CR, jbsl_pkg::CH_LF: ;
            jbsl_pkg::CH_QUOTE: mode = LM_STR;
            jbsl_pkg::CH_LBRK: add_done(jbsl_pkg::TK_LBRACKET);
            jbsl_pkg::CH_RBRK: add_done(jbsl_pkg::TK_RBRACKET);
            jbsl_pkg::CH_LBRACE: add_done(jbsl_pkg::TK_LBRACE);
            jbsl_pkg::CH_RBRACE: add_done(jbsl_pkg::TK_RBRACE);
            jbsl_pkg::CH_COLON: add_done(jbsl_pkg::TK_COLON);
            jbsl_pkg::CH_COMMA: add_done(jbsl_pkg::TK_COMMA);
            jbsl_pkg::CH_SLASH: mode = LM_SLASH;
            default: begin
               if (word_char(b)) begin
                  mode = LM_WORD; wclass = jbsl_pkg::WC_RESET;
                  feed_word(b); text_byte(b);
               end else raise_fault(jbsl_pkg::FLT_BAD_CHAR);
            end
         endcase
      endfunction

      function void emit_code(logic [20:0] cp);
         if (cp < 21'h80) text_byte(cp[7:0]);
         else if (cp < 21'h800) begin
            text_byte({3'b110, cp[10:6]}); text_byte({2'b10, cp[5:0]});
         end else if (cp < 21'h10000) begin
            text_byte({4'b1110, cp[15:12]}); text_byte({2'b10, cp[11:6]});
            text_byte({2'b10, cp[5:0]});
         end else begin
            text_byte({5'b11110, cp[20:18]}); text_byte({2'b10, cp[17:12]});
            text_byte({2'b10, cp[11:6]}); text_byte({2'b10, cp[5:0]});
         end
      endfunction

      // returns 1 with the finished unit after the fourth digit
      function bit add_hex(logic [7:0] b, output logic [15:0] unit);
         logic [3:0] v;
         v = 4'd0;
         if (b >= "0" && b <= "9") v = 4'(b - "0");
         else if (b >= "A" && b <= "F") v = 4'(b - "A" + 8'd10);
         else if (b >= "a" && b <= "f") v = 4'(b - "a" + 8'd10);
         else hex_err = 1;
         accum = {accum[11:0], v};
         unit = 16'h0000;
         if (hex_n < 3) begin
            hex_n++;
            return 0;
         end
         hex_n = 0;
         unit = hex_err ? 16'h0 : accum;
         accum = '0; hex_err = 0;
         return 1;
      endfunction

      function void lex_byte(logic [7:0] b);
         logic [15:0] u;
         case (mode)
            LM_IDLE: idle_byte(b);
            LM_SLASH: begin
               if (b == "/") mode = LM_LINE;
               else if (b == "*") mode = LM_BLOCK;
               else raise_fault(jbsl_pkg::FLT_BAD_CHAR);
            end
            LM_LINE: if (b == jbsl_pkg::CH_LF) mode = LM_IDLE;
            LM_BLOCK: if (b == "*") mode = LM_BSTAR;
            LM_BSTAR: begin
               if (b == "/") mode = LM_IDLE;
               else if (b != "*") mode = LM_BLOCK;
            end
            LM_STR: begin
               if (b == jbsl_pkg::CH_QUOTE) begin
                  add_done(jbsl_pkg::TK_STRING); mode = LM_IDLE;
               end else if (b == jbsl_pkg::CH_BSLASH) mode = LM_ESC;
               else text_byte(b);
            end
            LM_ESC: begin
               mode = LM_STR;
               case (b)
                  "b": text_byte(8'h08);
                  "f": text_byte(8'h0C);
                  "n": text_byte(8'h0A);
                  "r": text_byte(8'h0D);
                  "t": text_byte(8'h09);
                  jbsl_pkg::CH_QUOTE, jbsl_pkg::CH_BSLASH, jbsl_pkg::CH_SLASH:
                     text_byte(b);
                  "u": begin
                     mode = LM_HEX1; hex_n = 0; accum = '0; hex_err = 0;
                  end
                  default: raise_fault(jbsl_pkg::FLT_BAD_ESC);
               endcase
            end
            LM_HEX1: if (add_hex(b, u)) begin
               if (u >= 16'hDC00) begin
                  if (u <= 16'hDFFF) raise_fault(jbsl_pkg::FLT_LONE_LOW);
                  else begin
                     emit_code({5'd0, u}); mode = LM_STR;
                  end
               end else if (u >= 16'hD800) begin
                  high_half = u; mode = LM_PBS;
               end else begin
                  emit_code({5'd0, u}); mode = LM_STR;
               end
            end
            LM_PBS: begin
               if (b == jbsl_pkg::CH_BSLASH) mode = LM_PU;
               else raise_fault(jbsl_pkg::FLT_NO_PAIR);
            end
            LM_PU: begin
               if (b == "u") begin
                  mode = LM_HEX2; hex_n = 0; accum = '0; hex_err = 0;
               end else raise_fault(jbsl_pkg::FLT_NO_PAIR);
            end
            LM_HEX2: if (add_hex(b, u)) begin
               if (u < 16'hDC00 || u > 16'hDFFF) raise_fault(jbsl_pkg::FLT_BAD_LOW);
               else begin
                  emit_code(21'h10000 + {1'b0, high_half[9:0], u[9:0]});
                  mode = LM_STR;
               end
            end
            LM_WORD: begin
               if (word_char(b)) begin
                  feed_word(b); text_byte(b);
               end else if (close_word()) idle_byte(b);
            end
            default: ;
         endcase
      endfunction

      // predict all words caused by one accepted byte
      function void note_byte(jbsl_pkg::req_type r);
         jbsl_pkg::tok_type kept[$];
         jbsl_pkg::rsp_type w;
         int n;
         step_toks.delete();
         if (r.data_byte == jbsl_pkg::CH_LF) begin
            if (line_cnt < POS_MAX) line_cnt++;
            col_cnt = 0;
         end else if (col_cnt < POS_MAX) col_cnt++;
         w.line_no = line_cnt[15:0];
         w.column_no = col_cnt[15:0];
         lex_byte(r.data_byte);
         if (r.text_end) begin
            if (mode == LM_SLASH) raise_fault(jbsl_pkg::FLT_BAD_CHAR);
            else if (mode == LM_WORD) void'(close_word());
            else if (mode >= LM_STR && mode <= LM_HEX2) begin
               // drop content of the final byte of an open string
               foreach (step_toks[i])
                  if (!(step_toks[i].has_text && !step_toks[i].done))
                     kept.push_back(step_toks[i]);
               step_toks = kept;
               raise_fault(jbsl_pkg::FLT_TRUNC);
            end
            add_done(jbsl_pkg::TK_END);
            clear_all();
         end
         n = (step_toks.size() > 4) ? 4 : step_toks.size();
         for (int i = 0; i < n; i++) begin
            w.token_kind = step_toks[i].kind;
            w.token_done = step_toks[i].done;
            w.has_text = step_toks[i].has_text;
            w.text_out = step_toks[i].text;
            w.fault = step_toks[i].fault;
            w.run_last = (i == n - 1);
            expected_words.push_back(w);
         end
      endfunction

      function void check_word(jbsl_pkg::rsp_type got);
         jbsl_pkg::rsp_type e;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
         end
         e = expected_words.pop_front();
         if (got.token_kind !== e.token_kind)
            report("token_kind", 16'(e.token_kind), 16'(got.token_kind));
         if (got.token_done !== e.token_done)
            report("token_done", 16'(e.token_done), 16'(got.token_done));
         if (got.has_text !== e.has_text)
            report("has_text", 16'(e.has_text), 16'(got.has_text));
         if (got.text_out !== e.text_out)
            report("text_out", 16'(e.text_out), 16'(got.text_out));
         if (got.fault !== e.fault) report("fault", 16'(e.fault), 16'(got.fault));
         if (got.line_no !== e.line_no) report("line_no", e.line_no, got.line_no);
         if (got.column_no !== e.column_no)
            report("column_no", e.column_no, got.column_no);
         if (got.run_last !== e.run_last)
            report("run_last", 16'(e.run_last), 16'(got.run_last));
      endfunction

      function void report(string fld, logic [15:0] e, logic [15:0] a);
         $display("%0t: %s expected %h actual %h", $time, fld, e, a);
         errors++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   jbsl_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   jbsl_pkg::rsp_type rsp_data;

   token_scoreboard sb = new();

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   json_byte_stream_lexer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // mostly no gap at all, often a short one, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // note words as they are accepted; both sides sample at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_data);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_data);
      end
   end

   // receiver: randomly stall ready
   initial begin
      int g;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   byte unsigned text_q[$];

   // present one byte and hold until accepted
   task automatic send_byte(logic [7:0] b, logic last);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{data_byte: b, text_end: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // push a whole text; the last byte carries text_end
   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic send_queue();
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic string hex4(logic [15:0] v);
      return $sformatf("%04h", v);
   endfunction

   // build one random fragment, mostly well formed
   function automatic void add_fragment();
      int k;
      k = $urandom_range(0, 19);
      case (k)
         0: add_str("[");
         1: add_str("]");
         2: add_str("{");
         3: add_str("}");
         4: add_str(":");
         5: add_str(", ");
         6: begin
            if ($urandom_range(0, 2) == 0) add_str("true ");
            else if ($urandom_range(0, 1) == 1) add_str("false\t");
            else add_str("null\n");
         end
         7: add_str($sformatf("%0d.%0d ", $urandom_range(0, 9999), $urandom_range(0, 99)));
         8: add_str("\"ab\\n\\t\\\"\\\\\\/\\b\\f\\r\"");
         9: add_str({"\"\\u", hex4(16'($urandom_range(0, 16'hD7FF))), "\""});
         10: add_str({"\"\\u", hex4(16'($urandom_range(16'hD800, 16'hDBFF))), "\\u",
                      hex4(16'($urandom_range(16'hDC00, 16'hDFFF))), "x\""});
         11: add_str("// note\n");
         12: add_str("/* c ** / */");
         13: add_str({"\"\\u", hex4(16'($urandom_range(16'hE000, 16'hFFFF))), "\""});
         14: add_str("x_Y.9 ");
         15: add_str(" \r\n");
         16: add_str("\"q\x7f\"");
         // broken pieces and noise
         17: text_q.push_back(8'($urandom_range(0, 255)));
         18: begin
            case ($urandom_range(0, 4))
               0: add_str("\"\\q");
               1: add_str("\"\\uDC00");
               2: add_str("\"\\uD800x");
               3: add_str("\"\\uD800\\uAAAA");
               default: add_str("\"\\uZ1g2\"");
            endcase
         end
         default: begin
            text_q.push_back(jbsl_pkg::CH_QUOTE);
            text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
            text_q.push_back(jbsl_pkg::CH_QUOTE);
         end
      endcase
   endfunction

   initial begin
      int sent;
      int wait_cycles;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: punctuation, keywords, escapes, pairs, comments, faults
      send_text("[{}]:,\n");
      send_text("true false null 12.5");
      send_text("\"\\u0041\\u00e9\\u20AC\\uD83D\\uDE00\\n\"");
      send_text("/*a*/// b\n\"x");
      send_text("trux");
      send_text("\"\\uDC00\"");
      send_text("\"\\uD800a\"");
      send_text("\"\\uD800\\uD800\"");
      send_text("\"\\x\"");
      send_text("# z");
      send_text("/");
      send_text("/* open");
      send_text("\"\\u12");
      send_byte(8'hFF, 1);
      send_byte(8'h00, 1);

      // random texts, mostly well-formed fragments
      sent = 0;
      while (sent < 200) begin
         for (int f = $urandom_range(1, 8); f > 0; f--) add_fragment();
         sent += text_q.size();
         send_queue();
      end
      req_valid <= 0;

      wait_cycles = 0;
      while (sb.expected_words.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (sb.expected_words.size() != 0) begin
         $display("%0t: %0d words never arrived", $time, sb.expected_words.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> json_byte_stream_lexer.f
hdl/jbsl_pkg.sv
hdl/jbsl_fifo.sv
hdl/jbsl_front.sv
hdl/jbsl_back.sv
hdl/json_byte_stream_lexer.sv
sim/json_byte_stream_lexer_tb.sv
